// ----- hdl/lp2c_pkg.sv -----
// shared types, constants and the arctangent table for the lidar polar to cartesian block
// no dependencies; the design modules in hdl take names from here by scope
`timescale 1ns / 1ps

package lp2c_pkg;

  // fixed-point widths of the rotation datapath
  localparam int XW        = 34;   // x and y, Q14 millimetres with headroom for the gain
  localparam int ZW        = 33;   // residual angle, 2^32 units per turn
  localparam int FRAC_BITS = 14;
  localparam int TABLE_LEN = 24;
  localparam int OUT_W     = 17;

  localparam logic [15:0] GAIN_Q16 = 16'd39797;

  typedef enum logic [1:0] {
    REG_MIN_RANGE   = 2'd0,
    REG_MAX_RANGE   = 2'd1,
    REG_START_ANGLE = 2'd2,
    REG_ANGLE_STEP  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] min_range;
    logic [15:0] max_range;
    logic [15:0] start_angle;
    logic [15:0] angle_step;
  } cfg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest
  function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- hdl/lp2c_sample_if.sv -----
// input channel: one lidar range sample with its beam index per item
// depends on nothing
`timescale 1ns / 1ps

interface lp2c_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic [11:0] beam_index;

  modport source (output valid, range_mm, beam_index, input ready);
  modport sink   (input valid, range_mm, beam_index, output ready);
endinterface

// ----- hdl/lp2c_point_if.sv -----
// output channel: one cartesian point per item
// depends on nothing
`timescale 1ns / 1ps

interface lp2c_point_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] x_mm;
  logic signed [16:0] y_mm;

  modport source (output valid, x_mm, y_mm, input ready);
  modport sink   (input valid, x_mm, y_mm, output ready);
endinterface

// ----- hdl/lp2c_prep.sv -----
// front of the pipeline: range substitution, bearing, quadrant fold and gain-scaled seed vector
// depends on lp2c_pkg
`timescale 1ns / 1ps

module lp2c_prep (
  input  logic            clk,
  input  logic            rst,
  input  lp2c_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [15:0]     in_range,
  input  logic [11:0]     in_beam,
  output logic            out_valid,
  input  logic            out_ready,
  output lp2c_pkg::vec_t  out_vec
);

  localparam int MAG_W = 30;

  // stage a: range select and beam * step
  logic        a_valid;
  logic        a_ready;
  logic [15:0] a_r;
  logic [15:0] a_prod;
  logic [27:0] prod_full;

  // stage b: bearing, fold and gain multiply
  logic             b_valid;
  logic             b_ready;
  logic [MAG_W-1:0] b_mag;
  logic             b_flip;
  logic [15:0]      b_sa;
  logic [15:0]      theta;
  logic             flip;
  logic [31:0]      mag_full;

  // stage c: signed seed vector
  logic                         c_ready;
  logic signed [lp2c_pkg::XW-1:0] x_pos;

  assign prod_full = in_beam * cfg.angle_step;

  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_r    <= (in_range <= cfg.min_range) ? cfg.max_range : in_range;
      a_prod <= prod_full[15:0];
    end
  end

  assign theta    = a_prod + cfg.start_angle;
  // bearing in [1/4, 3/4) turn gets folded by half a turn
  assign flip     = theta[15] ^ theta[14];
  assign mag_full = a_r * lp2c_pkg::GAIN_Q16;
  assign b_ready  = !b_valid || c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_mag  <= mag_full[31:2];
      b_flip <= flip;
      b_sa   <= {theta[15] ^ flip, theta[14:0]};
    end
  end

  assign c_ready = !out_valid || out_ready;
  assign x_pos   = lp2c_pkg::XW'(b_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_ready) begin
      out_valid <= b_valid;
    end
    if (c_ready && b_valid) begin
      out_vec.x <= b_flip ? -x_pos : x_pos;
      out_vec.y <= '0;
      out_vec.z <= {{(lp2c_pkg::ZW - 32){b_sa[15]}}, b_sa, 16'h0000};
    end
  end

endmodule

// ----- hdl/lp2c_cell.sv -----
// one rotation step of the cordic chain, registered, with its own valid and backpressure
// depends on lp2c_pkg
`timescale 1ns / 1ps

module lp2c_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lp2c_pkg::vec_t in_vec,
  output logic           out_valid,
  input  logic           out_ready,
  output lp2c_pkg::vec_t out_vec
);

  logic signed [lp2c_pkg::XW-1:0] dx;
  logic signed [lp2c_pkg::XW-1:0] dy;
  logic signed [lp2c_pkg::ZW-1:0] ang;
  lp2c_pkg::vec_t                 nxt;

  assign dx  = $signed(in_vec.y) >>> IDX;
  assign dy  = $signed(in_vec.x) >>> IDX;
  assign ang = $signed(lp2c_pkg::ZW'(lp2c_pkg::atan_turn32(5'(IDX))));

  always_comb begin
    if (!in_vec.z[lp2c_pkg::ZW-1]) begin
      nxt.x = in_vec.x - dx;
      nxt.y = in_vec.y + dy;
      nxt.z = in_vec.z - ang;
    end else begin
      nxt.x = in_vec.x + dx;
      nxt.y = in_vec.y - dy;
      nxt.z = in_vec.z + ang;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_vec <= nxt;
    end
  end

endmodule

// ----- hdl/lp2c_out.sv -----
// output register: rounds the q14 vector to millimetres and saturates to 17 bits
// depends on lp2c_pkg
`timescale 1ns / 1ps

module lp2c_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lp2c_pkg::vec_t      in_vec,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [16:0]  out_x,
  output logic signed [16:0]  out_y
);

  localparam int SW = lp2c_pkg::XW + 1;
  localparam int QW = SW - lp2c_pkg::FRAC_BITS;
  localparam int OW = lp2c_pkg::OUT_W;

  function automatic logic [OW-1:0] round_sat(input logic [lp2c_pkg::XW-1:0] v);
    logic [SW-1:0] s;
    logic [QW-1:0] q;
    logic [OW-1:0] r;
    s = {v[lp2c_pkg::XW-1], v} + SW'(1 << (lp2c_pkg::FRAC_BITS - 1));
    q = s[SW-1:lp2c_pkg::FRAC_BITS];
    // bits above the field must all match the sign, else clamp
    if (q[QW-1:OW-1] == '0 || q[QW-1:OW-1] == '1) begin
      r = q[OW-1:0];
    end else begin
      r = q[QW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_x <= $signed(round_sat(in_vec.x));
      out_y <= $signed(round_sat(in_vec.y));
    end
  end

endmodule

// ----- hdl/lidar_polar_to_cartesian.sv -----
// top level: config registers, front stages, chain of cordic cells and output register
// depends on lp2c_pkg, lp2c_sample_if, lp2c_point_if, lp2c_prep, lp2c_cell, lp2c_out
`timescale 1ns / 1ps

//  channel   dir  handshake      payload
//  samples   in   valid/ready    range_mm[15:0], beam_index[11:0]
//  points    out  valid/ready    x_mm[16:0] signed, y_mm[16:0] signed
//  apb       in   psel/penable   paddr[3:0], pwdata[31:0], prdata[31:0], pready
//
//  one item per cycle while the output accepts; three front stages, one cell per rotation
//  step (CORDIC_STAGES capped at the table length of 24), then one output register
//  every stage has its own valid bit and takes a new item when empty or draining,
//  so bubbles close up under a stall at the output
//  synchronous reset empties the pipeline and loads the register defaults

module lidar_polar_to_cartesian #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  lp2c_sample_if.sink  samples,
  lp2c_point_if.source points
);

  localparam int NS = (CORDIC_STAGES > lp2c_pkg::TABLE_LEN) ? lp2c_pkg::TABLE_LEN
                                                             : CORDIC_STAGES;

  lp2c_pkg::cfg_t     cfg;
  lp2c_pkg::reg_idx_t reg_sel;
  lp2c_pkg::vec_t     stage_vec [NS+1];
  logic [NS:0]        stage_valid;
  logic [NS:0]        stage_ready;

  assign pready  = 1'b1;
  assign reg_sel = lp2c_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_range   <= 16'd0;
      cfg.max_range   <= 16'hFFFF;
      cfg.start_angle <= 16'd0;
      cfg.angle_step  <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        lp2c_pkg::REG_MIN_RANGE:   cfg.min_range   <= pwdata[15:0];
        lp2c_pkg::REG_MAX_RANGE:   cfg.max_range   <= pwdata[15:0];
        lp2c_pkg::REG_START_ANGLE: cfg.start_angle <= pwdata[15:0];
        lp2c_pkg::REG_ANGLE_STEP:  cfg.angle_step  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lp2c_pkg::REG_MIN_RANGE:   prdata = {16'h0000, cfg.min_range};
      lp2c_pkg::REG_MAX_RANGE:   prdata = {16'h0000, cfg.max_range};
      lp2c_pkg::REG_START_ANGLE: prdata = {16'h0000, cfg.start_angle};
      lp2c_pkg::REG_ANGLE_STEP:  prdata = {16'h0000, cfg.angle_step};
      default:                   prdata = 32'h0000_0000;
    endcase
  end

  lp2c_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_range  (samples.range_mm),
    .in_beam   (samples.beam_index),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_vec   (stage_vec[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_cell
    lp2c_cell #(
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_ready  (stage_ready[k]),
      .in_vec    (stage_vec[k]),
      .out_valid (stage_valid[k+1]),
      .out_ready (stage_ready[k+1]),
      .out_vec   (stage_vec[k+1])
    );
  end

  lp2c_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[NS]),
    .in_ready  (stage_ready[NS]),
    .in_vec    (stage_vec[NS]),
    .out_valid (points.valid),
    .out_ready (points.ready),
    .out_x     (points.x_mm),
    .out_y     (points.y_mm)
  );

endmodule
